>>> sv/gcrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcrd_pkg: shared types and constants of the great-circle distance unit
// Field widths, fixed-point constants, the CORDIC arctangent table, the
// sequencer states and the item that travels from front to back.
// ----------------------------------------------------------------------------
package gcrd_pkg;

  // Field widths
  localparam int LAT_W   = 28;
  localparam int LON_W   = 29;
  localparam int DLON_W  = 30;
  localparam int RAD_W   = 30;
  localparam int DIST_W  = 32;
  localparam int TOTAL_W = 48;

  // Datapath widths: multiplier operands, product, CORDIC registers
  localparam int OP_W   = 34;
  localparam int PROD_W = 2 * OP_W;
  localparam int CW     = 36;

  // Configuration port
  localparam int ADDR_W = 3;
  localparam logic REG_RADIUS = 1'b0;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 30'd418014036;

  // Fixed-point constants (Q30 radians, Q36 degree-to-radian factor)
  localparam logic [30:0] DEG2RAD_Q36     = 31'd1199381129;
  localparam logic [30:0] CORDIC_GAIN_Q30 = 31'd652032875;
  localparam logic [30:0] HALF_PI_Q30     = 31'd1686629713;

  // atan(2^-i) in Q30
  localparam logic [30:0] ATAN_Q30 [32] = '{
    31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
    31'd33543515, 31'd16775851, 31'd8388438, 31'd4194283, 31'd2097149,
    31'd1048576, 31'd524288, 31'd262144, 31'd131072, 31'd65536, 31'd32768,
    31'd16384, 31'd8192, 31'd4096, 31'd2048, 31'd1024, 31'd512, 31'd256,
    31'd128, 31'd64, 31'd32, 31'd16, 31'd8, 31'd4, 31'd2, 31'd1, 31'd0
  };

  // What the front decided about a waypoint
  typedef enum logic [1:0] {
    KIND_FIRST,
    KIND_START,
    KIND_SEG
  } kind_e;

  typedef struct packed {
    kind_e                    kind;
    logic signed [LAT_W-1:0]  lat_prev;
    logic signed [LON_W-1:0]  lon_prev;
    logic signed [LAT_W-1:0]  lat;
    logic signed [LON_W-1:0]  lon;
  } item_t;

  // Back-end sequencer
  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_RED,
    S_FOLD,
    S_D2R,
    S_RINIT,
    S_ROT,
    S_M1,
    S_M2,
    S_M3,
    S_M4,
    S_M5,
    S_M6,
    S_SQ1,
    S_SQ2,
    S_SQRT,
    S_VINIT,
    S_VEC,
    S_DM,
    S_DFIN,
    S_OUT
  } state_e;

endpackage

>>> sv/gcrd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcrd_front: waypoint intake and classification
// Accepts waypoints, keeps the previous point, tags each beat as route start,
// first point or segment and queues it (two entries) for the back end.
// ----------------------------------------------------------------------------
module gcrd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic signed [gcrd_pkg::LAT_W-1:0] latitude_i,
  input  logic signed [gcrd_pkg::LON_W-1:0] longitude_i,
  input  logic                              route_start_i,
  output logic                              q_valid_o,
  output gcrd_pkg::item_t                   q_item_o,
  input  logic                              q_pop_i
);

  gcrd_pkg::item_t                   mem_q [2];
  logic                              wr_ptr_q, rd_ptr_q;
  logic [1:0]                        count_q;
  logic                              have_prev_q;
  logic signed [gcrd_pkg::LAT_W-1:0] prev_lat_q;
  logic signed [gcrd_pkg::LON_W-1:0] prev_lon_q;
  logic                              do_push, do_pop;
  gcrd_pkg::item_t                   new_item;

  assign full      = (count_q == 2'd2);
  assign q_valid_o = (count_q != 2'd0);
  assign q_item_o  = mem_q[rd_ptr_q];
  assign do_push   = push && !full;
  assign do_pop    = q_pop_i && q_valid_o;

  // Classify the incoming beat
  always_comb begin
    new_item.lat_prev = prev_lat_q;
    new_item.lon_prev = prev_lon_q;
    new_item.lat      = latitude_i;
    new_item.lon      = longitude_i;
    if (route_start_i) begin
      new_item.kind = gcrd_pkg::KIND_START;
    end else if (have_prev_q) begin
      new_item.kind = gcrd_pkg::KIND_SEG;
    end else begin
      new_item.kind = gcrd_pkg::KIND_FIRST;
    end
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

  // Pointers, fill count and previous point
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q    <= 1'b0;
      rd_ptr_q    <= 1'b0;
      count_q     <= 2'd0;
      have_prev_q <= 1'b0;
      prev_lat_q  <= '0;
      prev_lon_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q    <= !wr_ptr_q;
        have_prev_q <= 1'b1;
        prev_lat_q  <= latitude_i;
        prev_lon_q  <= longitude_i;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (!do_push && do_pop) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

>>> sv/gcrd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcrd_back: distance engine
// Sequencer over one shared multiplier, a CORDIC unit (rotation and
// vectoring), a bit-pair square root and an angle reducer. Keeps the route
// total and a one-beat result register.
// ----------------------------------------------------------------------------
module gcrd_back #(
  parameter int ANGLE_FRAC_BITS   = 20,
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                q_valid_i,
  input  gcrd_pkg::item_t                     q_item_i,
  output logic                                q_pop_o,
  input  logic [gcrd_pkg::RAD_W-1:0]          radius_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [gcrd_pkg::DIST_W-1:0]         segment_distance_o,
  output logic [gcrd_pkg::TOTAL_W-1:0]        route_total_o,
  output logic                                segment_valid_o
);

  localparam int OP_W   = gcrd_pkg::OP_W;
  localparam int PROD_W = gcrd_pkg::PROD_W;
  localparam int CW     = gcrd_pkg::CW;
  localparam int RW     = 40;
  localparam int CNT_W  = 6;

  // Angle reduction constants
  localparam logic [63:0] FULL    = 64'd360 << ANGLE_FRAC_BITS;
  localparam logic [63:0] HALF    = 64'd180 << ANGLE_FRAC_BITS;
  localparam logic [63:0] QUARTER = 64'd90 << ANGLE_FRAC_BITS;
  localparam logic signed [RW-1:0] FULL_S    = FULL[RW-1:0];
  localparam logic signed [RW-1:0] HALF_S    = HALF[RW-1:0];
  localparam logic signed [RW-1:0] QUARTER_S = QUARTER[RW-1:0];
  localparam int FULL_LOG  = $clog2(FULL);
  localparam int RED_STEPS = (FULL_LOG < 31) ? (31 - FULL_LOG) : 1;
  localparam logic [CNT_W-1:0] RED_LAST  = CNT_W'(RED_STEPS - 1);
  localparam logic [CNT_W-1:0] ITER_LAST = CNT_W'(CORDIC_ITERATIONS - 1);
  localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(31);
  localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
  localparam int D2R_SHIFT = ANGLE_FRAC_BITS + 6;
  localparam logic [63:0] D2R_ROUND = 64'd1 << (ANGLE_FRAC_BITS + 5);

  localparam logic signed [PROD_W:0] SUM_ROUND = (PROD_W + 1)'(64'd1 << 29);
  localparam logic signed [PROD_W:0] ONE_Q30   = (PROD_W + 1)'(64'd1 << 30);

  gcrd_pkg::state_e                  state_q, state_d;
  logic [CNT_W-1:0]                  cnt_q, cnt_d;
  logic [1:0]                        idx_q, idx_d;
  gcrd_pkg::item_t                   item_q, item_d;
  logic [30:0]                       m_q, m_d;
  logic                              neg_q, neg_d, flip_q, flip_d;
  logic signed [CW-1:0]              x_q, x_d, y_q, y_d, z_q, z_d;
  logic signed [OP_W-1:0]            s_q [3];
  logic signed [OP_W-1:0]            s_d [3];
  logic signed [OP_W-1:0]            c_q [3];
  logic signed [OP_W-1:0]            c_d [3];
  logic signed [OP_W-1:0]            op_a_q, op_a_d, op_b_q, op_b_d;
  logic signed [PROD_W-1:0]          mul_q, p1_q, p1_d;
  logic signed [31:0]                a_q, a_d;
  logic [63:0]                       sv_q, sv_d, root_q, root_d;
  logic [gcrd_pkg::DIST_W-1:0]       dist_q, dist_d;
  logic                              seg_q, seg_d;
  logic [gcrd_pkg::TOTAL_W-1:0]      total_q, total_d;
  logic                              res_valid_q, res_valid_d;
  logic [gcrd_pkg::DIST_W-1:0]       res_dist_q;
  logic [gcrd_pkg::TOTAL_W-1:0]      res_total_q;
  logic                              res_seg_q;
  logic                              res_load;

  // Combinational helpers
  logic signed [gcrd_pkg::DLON_W-1:0] dlon;
  logic signed [30:0]                 ang;
  logic [63:0]                        red_sub;
  logic signed [RW-1:0]               r_s, r_a, r_f, r_mag;
  logic [63:0]                        d2r_sum, z_mag;
  logic signed [CW-1:0]               dx, dy, at, x_n, y_n, z_n, z_clip;
  logic                               ccw;
  logic signed [PROD_W-1:0]           c12;
  logic signed [PROD_W:0]             sum, rnd;
  logic [63:0]                        sq_bit, sq_trial, dsum;
  logic [gcrd_pkg::TOTAL_W:0]         tsum;

  assign segment_distance_o = res_dist_q;
  assign route_total_o      = res_total_q;
  assign segment_valid_o    = res_seg_q;
  assign empty              = !res_valid_q;

  // Angle source for the current sine/cosine
  assign dlon = gcrd_pkg::DLON_W'(item_q.lon) - gcrd_pkg::DLON_W'(item_q.lon_prev);
  always_comb begin
    unique case (idx_q)
      2'd0:    ang = 31'(item_q.lat_prev);
      2'd1:    ang = 31'(item_q.lat);
      default: ang = 31'(dlon);
    endcase
  end

  // Reduction, fold and CORDIC step
  assign red_sub = FULL << cnt_q;
  assign r_s   = neg_q ? -$signed({9'b0, m_q}) : $signed({9'b0, m_q});
  assign r_a   = (r_s >= HALF_S) ? (r_s - FULL_S) :
                 (r_s < -HALF_S) ? (r_s + FULL_S) : r_s;
  assign r_f   = (r_a > QUARTER_S) ? (HALF_S - r_a) :
                 (r_a < -QUARTER_S) ? (-HALF_S - r_a) : r_a;
  assign r_mag = r_f[RW-1] ? -r_f : r_f;
  assign d2r_sum = mul_q[63:0] + D2R_ROUND;
  assign z_mag   = d2r_sum >> D2R_SHIFT;

  assign dx  = y_q >>> cnt_q;
  assign dy  = x_q >>> cnt_q;
  assign at  = $signed({5'b0, gcrd_pkg::ATAN_Q30[cnt_q[4:0]]});
  assign ccw = (state_q == gcrd_pkg::S_ROT) ? !z_q[CW-1] : (y_q <= 0);
  assign x_n = ccw ? (x_q - dx) : (x_q + dx);
  assign y_n = ccw ? (y_q + dy) : (y_q - dy);
  assign z_n = ccw ? (z_q - at) : (z_q + at);
  assign z_clip = z_n[CW-1] ? '0 : z_n;

  // Dot product, square root and final scale
  assign c12  = mul_q >>> 30;
  assign sum  = (PROD_W + 1)'(p1_q) + (PROD_W + 1)'(mul_q);
  assign rnd  = (sum + SUM_ROUND) >>> 30;
  assign sq_bit   = 64'd1 << {cnt_q, 1'b0};
  assign sq_trial = root_q + sq_bit;
  assign dsum = (mul_q[63:0] + (64'd1 << 29)) >> 30;
  assign tsum = {1'b0, total_q} + (gcrd_pkg::TOTAL_W + 1)'(dist_q);

  assign res_load = (state_q == gcrd_pkg::S_OUT) && (!res_valid_q || pop);

  // Sequencer: next state and datapath loads
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    idx_d   = idx_q;
    item_d  = item_q;
    m_d     = m_q;
    neg_d   = neg_q;
    flip_d  = flip_q;
    x_d     = x_q;
    y_d     = y_q;
    z_d     = z_q;
    s_d     = s_q;
    c_d     = c_q;
    op_a_d  = op_a_q;
    op_b_d  = op_b_q;
    p1_d    = p1_q;
    a_d     = a_q;
    sv_d    = sv_q;
    root_d  = root_q;
    dist_d  = dist_q;
    seg_d   = seg_q;
    total_d = total_q;
    q_pop_o = 1'b0;
    res_valid_d = res_valid_q && !pop;

    unique case (state_q)
      gcrd_pkg::S_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          item_d  = q_item_i;
          dist_d  = '0;
          seg_d   = 1'b0;
          idx_d   = 2'd0;
          unique case (q_item_i.kind)
            gcrd_pkg::KIND_START: begin
              total_d = '0;
              state_d = gcrd_pkg::S_OUT;
            end
            gcrd_pkg::KIND_SEG:   state_d = gcrd_pkg::S_LOAD;
            default:              state_d = gcrd_pkg::S_OUT;
          endcase
        end
      end
      gcrd_pkg::S_LOAD: begin
        neg_d   = ang[30];
        m_d     = ang[30] ? 31'(-ang) : 31'(ang);
        cnt_d   = RED_LAST;
        state_d = gcrd_pkg::S_RED;
      end
      gcrd_pkg::S_RED: begin
        if ({33'b0, m_q} >= red_sub) begin
          m_d = m_q - red_sub[30:0];
        end
        if (cnt_q == '0) begin
          state_d = gcrd_pkg::S_FOLD;
        end else begin
          cnt_d = cnt_q - CNT_ONE;
        end
      end
      gcrd_pkg::S_FOLD: begin
        flip_d  = (r_a > QUARTER_S) || (r_a < -QUARTER_S);
        neg_d   = r_f[RW-1];
        op_a_d  = $signed(r_mag[OP_W-1:0]);
        op_b_d  = $signed({3'b0, gcrd_pkg::DEG2RAD_Q36});
        state_d = gcrd_pkg::S_D2R;
      end
      gcrd_pkg::S_D2R: state_d = gcrd_pkg::S_RINIT;
      gcrd_pkg::S_RINIT: begin
        z_d     = neg_q ? -$signed(z_mag[CW-1:0]) : $signed(z_mag[CW-1:0]);
        x_d     = $signed({5'b0, gcrd_pkg::CORDIC_GAIN_Q30});
        y_d     = '0;
        cnt_d   = '0;
        state_d = gcrd_pkg::S_ROT;
      end
      gcrd_pkg::S_ROT: begin
        x_d = x_n;
        y_d = y_n;
        z_d = z_n;
        if (cnt_q == ITER_LAST) begin
          s_d[idx_q] = y_n[OP_W-1:0];
          c_d[idx_q] = flip_q ? -x_n[OP_W-1:0] : x_n[OP_W-1:0];
          if (idx_q == 2'd2) begin
            state_d = gcrd_pkg::S_M1;
          end else begin
            idx_d   = idx_q + 2'd1;
            state_d = gcrd_pkg::S_LOAD;
          end
        end else begin
          cnt_d = cnt_q + CNT_ONE;
        end
      end
      gcrd_pkg::S_M1: begin
        op_a_d  = s_q[0];
        op_b_d  = s_q[1];
        state_d = gcrd_pkg::S_M2;
      end
      gcrd_pkg::S_M2: begin
        op_a_d  = c_q[0];
        op_b_d  = c_q[1];
        state_d = gcrd_pkg::S_M3;
      end
      gcrd_pkg::S_M3: begin
        p1_d    = mul_q;
        state_d = gcrd_pkg::S_M4;
      end
      gcrd_pkg::S_M4: begin
        op_a_d  = $signed(c12[OP_W-1:0]);
        op_b_d  = c_q[2];
        state_d = gcrd_pkg::S_M5;
      end
      gcrd_pkg::S_M5: state_d = gcrd_pkg::S_M6;
      gcrd_pkg::S_M6: begin
        // acos argument, clamped to [-1, 1]
        if (rnd > ONE_Q30) begin
          a_d = 32'sd1073741824;
        end else if (rnd < -ONE_Q30) begin
          a_d = -32'sd1073741824;
        end else begin
          a_d = $signed(rnd[31:0]);
        end
        op_a_d  = OP_W'(a_d);
        op_b_d  = OP_W'(a_d);
        state_d = gcrd_pkg::S_SQ1;
      end
      gcrd_pkg::S_SQ1: state_d = gcrd_pkg::S_SQ2;
      gcrd_pkg::S_SQ2: begin
        sv_d    = (64'd1 << 60) - mul_q[63:0];
        root_d  = '0;
        cnt_d   = SQRT_LAST;
        state_d = gcrd_pkg::S_SQRT;
      end
      gcrd_pkg::S_SQRT: begin
        if (sv_q >= sq_trial) begin
          sv_d   = sv_q - sq_trial;
          root_d = (root_q >> 1) + sq_bit;
        end else begin
          root_d = root_q >> 1;
        end
        if (cnt_q == '0) begin
          state_d = gcrd_pkg::S_VINIT;
        end else begin
          cnt_d = cnt_q - CNT_ONE;
        end
      end
      gcrd_pkg::S_VINIT: begin
        // negative argument: turn by a quarter circle first
        if (a_q < 0) begin
          x_d = $signed({4'b0, root_q[31:0]});
          y_d = -CW'(a_q);
          z_d = $signed({5'b0, gcrd_pkg::HALF_PI_Q30});
        end else begin
          x_d = CW'(a_q);
          y_d = $signed({4'b0, root_q[31:0]});
          z_d = '0;
        end
        cnt_d   = '0;
        state_d = gcrd_pkg::S_VEC;
      end
      gcrd_pkg::S_VEC: begin
        x_d = x_n;
        y_d = y_n;
        z_d = z_n;
        if (cnt_q == ITER_LAST) begin
          op_a_d  = $signed(z_clip[OP_W-1:0]);
          op_b_d  = $signed({4'b0, radius_i});
          state_d = gcrd_pkg::S_DM;
        end else begin
          cnt_d = cnt_q + CNT_ONE;
        end
      end
      gcrd_pkg::S_DM: state_d = gcrd_pkg::S_DFIN;
      gcrd_pkg::S_DFIN: begin
        dist_d  = (|dsum[63:32]) ? '1 : dsum[31:0];
        seg_d   = 1'b1;
        state_d = gcrd_pkg::S_OUT;
      end
      gcrd_pkg::S_OUT: begin
        if (res_load) begin
          if (seg_q) begin
            total_d = tsum[gcrd_pkg::TOTAL_W] ? '1 : tsum[gcrd_pkg::TOTAL_W-1:0];
          end
          res_valid_d = 1'b1;
          state_d     = gcrd_pkg::S_IDLE;
        end
      end
      default: state_d = gcrd_pkg::S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gcrd_pkg::S_IDLE;
      cnt_q       <= '0;
      idx_q       <= '0;
      total_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      idx_q       <= idx_d;
      total_q     <= total_d;
      res_valid_q <= res_valid_d;
    end
  end

  // Datapath registers and shared multiplier
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
    m_q    <= m_d;
    neg_q  <= neg_d;
    flip_q <= flip_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
    s_q    <= s_d;
    c_q    <= c_d;
    op_a_q <= op_a_d;
    op_b_q <= op_b_d;
    mul_q  <= op_a_q * op_b_q;
    p1_q   <= p1_d;
    a_q    <= a_d;
    sv_q   <= sv_d;
    root_q <= root_d;
    dist_q <= dist_d;
    seg_q  <= seg_d;
    if (res_load) begin
      res_dist_q  <= dist_q;
      res_total_q <= seg_q ? total_d : total_q;
      res_seg_q   <= seg_q;
    end
  end

endmodule

>>> sv/great_circle_route_distance_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_route_distance_unit: route distance by law of cosines
// Waypoints in, one result beat per waypoint out, with a running total.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel: a waypoint beat (latitude_i, longitude_i, route_start_i)
//   is taken when push is high and full is low. Two beats queue in front.
//   Result channel: while empty is low the oldest result is on
//   segment_distance_o, route_total_o, segment_valid_o; pop takes it.
//   APB port: register 0 (byte address 0) holds the sphere radius.
//   Engine: a segment goes through three sine/cosine CORDIC passes (each
//   after R angle reduction steps, R = 2 at ANGLE_FRAC_BITS = 20), a
//   32-step square root and a vectoring pass over one multiplier; a route
//   start or first point skips them. The engine works one beat at a time.
//   A stalled result stays put; the engine finishes the next beat and then
//   waits on the result register, and the input queue fills and raises full.
//   Reset clears the total, the previous point and all queues; the radius
//   returns to 6378.388 km.
module great_circle_route_distance_unit #(
  parameter int ANGLE_FRAC_BITS   = 20,
  parameter int CORDIC_ITERATIONS = 24
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                push,
  output logic                                full,
  input  logic signed [gcrd_pkg::LAT_W-1:0]   latitude_i,
  input  logic signed [gcrd_pkg::LON_W-1:0]   longitude_i,
  input  logic                                route_start_i,
  output logic                                empty,
  input  logic                                pop,
  output logic [gcrd_pkg::DIST_W-1:0]         segment_distance_o,
  output logic [gcrd_pkg::TOTAL_W-1:0]        route_total_o,
  output logic                                segment_valid_o,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gcrd_pkg::ADDR_W-1:0]         paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);

  logic                             q_valid, q_pop;
  gcrd_pkg::item_t                  q_item;
  logic [gcrd_pkg::RAD_W-1:0]       radius_q;
  logic                             reg_idx;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_idx = paddr[gcrd_pkg::ADDR_W-1];
  assign prdata  = (reg_idx == gcrd_pkg::REG_RADIUS) ? {2'b0, radius_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= gcrd_pkg::RADIUS_RESET;
    end else if (psel && penable && pwrite && pready &&
                 (reg_idx == gcrd_pkg::REG_RADIUS)) begin
      radius_q <= pwdata[gcrd_pkg::RAD_W-1:0];
    end
  end

  gcrd_front u_front (
    .clk_i,
    .rst_ni,
    .push,
    .full,
    .latitude_i,
    .longitude_i,
    .route_start_i,
    .q_valid_o (q_valid),
    .q_item_o  (q_item),
    .q_pop_i   (q_pop)
  );

  gcrd_back #(
    .ANGLE_FRAC_BITS   (ANGLE_FRAC_BITS),
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_back (
    .clk_i,
    .rst_ni,
    .q_valid_i (q_valid),
    .q_item_i  (q_item),
    .q_pop_o   (q_pop),
    .radius_i  (radius_q),
    .empty,
    .pop,
    .segment_distance_o,
    .route_total_o,
    .segment_valid_o
  );

endmodule

>>> sv/gcrd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcrd_checker: port-level checks of the route distance unit
// Tracks beats in flight and checks result and register behavior.
// ----------------------------------------------------------------------------
module gcrd_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        push,
  input logic                        full,
  input logic                        pop,
  input logic                        empty,
  input logic [31:0]                 segment_distance_o,
  input logic [47:0]                 route_total_o,
  input logic                        segment_valid_o,
  input logic                        psel,
  input logic                        penable,
  input logic                        pwrite,
  input logic [gcrd_pkg::ADDR_W-1:0] paddr,
  input logic [31:0]                 pwdata,
  input logic [31:0]                 prdata
);

  logic [3:0] inflight_q;
  logic       in_beat, out_beat;

  assign in_beat  = push && !full;
  assign out_beat = pop && !empty;

  // Beats accepted but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 4'(in_beat) - 4'(out_beat);
    end
  end

  // No result without an accepted waypoint
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    inflight_q == 4'd0 |-> empty)
    else $error("result shown with no waypoint in flight");

  // A waypoint without a segment carries zero distance
  a_zero_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !segment_valid_o |-> segment_distance_o == '0)
    else $error("nonzero distance on a non-segment result");

  // A stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !pop |=> !empty && $stable(segment_distance_o) &&
      $stable(route_total_o) && $stable(segment_valid_o))
    else $error("stalled result changed");

  // Radius reads back what was written
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite &&
     paddr[gcrd_pkg::ADDR_W-1] == gcrd_pkg::REG_RADIUS) ##1
    (paddr[gcrd_pkg::ADDR_W-1] == gcrd_pkg::REG_RADIUS) |->
      prdata == {2'b0, $past(pwdata[29:0])})
    else $error("radius readback mismatch");

endmodule

bind great_circle_route_distance_unit gcrd_checker u_gcrd_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .push               (push),
  .full               (full),
  .pop                (pop),
  .empty              (empty),
  .segment_distance_o (segment_distance_o),
  .route_total_o      (route_total_o),
  .segment_valid_o    (segment_valid_o),
  .psel               (psel),
  .penable            (penable),
  .pwrite             (pwrite),
  .paddr              (paddr),
  .pwdata             (pwdata),
  .prdata             (prdata)
);
